@@ hw/rtl/asg_pkg.sv @@
`timescale 1ns / 1ps
package asg_pkg;

  localparam int ANGLE_W   = 32;
  localparam int TIME_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  // scan mode codes, the two unused codes act as fixed pointing
  typedef enum logic [2:0] {
    MODE_FIXED = 3'd0,
    MODE_CIRC  = 3'd1,
    MODE_BSECT = 3'd2,
    MODE_USECT = 3'd3,
    MODE_BRAST = 3'd4,
    MODE_URAST = 3'd5
  } scan_mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_RATE  = 3'd1,
    REG_START = 3'd2,
    REG_END   = 3'd3,
    REG_FLY   = 3'd4,
    REG_BARS  = 3'd5,
    REG_BARW  = 3'd6,
    REG_BASE  = 3'd7
  } cfg_reg_t;

endpackage

@@ hw/rtl/asg_div_pipe.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage
module asg_div_pipe #(
  parameter int NW = 48,
  parameter int MW = 49,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [MW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [MW-1:0] rem,
  output logic [SW-1:0] side_out
);

  logic          v_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [NW-1:0] q_q [NW];
  logic [MW-1:0] r_q [NW];
  logic [MW-1:0] d_q [NW];
  logic [SW-1:0] x_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_src;
    logic [NW-1:0] n_src;
    logic [NW-1:0] q_src;
    logic [MW-1:0] r_src;
    logic [MW-1:0] d_src;
    logic [SW-1:0] x_src;
    logic [MW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_src = in_valid;
      assign n_src = num;
      assign q_src = '0;
      assign r_src = '0;
      assign d_src = den;
      assign x_src = side_in;
    end else begin : g_next
      assign v_src = v_q[k-1];
      assign n_src = n_q[k-1];
      assign q_src = q_q[k-1];
      assign r_src = r_q[k-1];
      assign d_src = d_q[k-1];
      assign x_src = x_q[k-1];
    end

    assign trial = {r_src, n_src[NW-1]};
    assign take  = (trial >= {1'b0, d_src});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= take ? MW'(trial - {1'b0, d_src}) : trial[MW-1:0];
        q_q[k] <= {q_src[NW-2:0], take};
        n_q[k] <= n_src << 1;
        d_q[k] <= d_src;
        x_q[k] <= x_src;
      end
    end
  end

  assign out_valid = v_q[NW-1];
  assign quo       = q_q[NW-1];
  assign rem       = r_q[NW-1];
  assign side_out  = x_q[NW-1];

endmodule

@@ hw/rtl/antenna_scan_angle_generator.sv @@
`timescale 1ns / 1ps
// Beam angle generator: each accepted time stamp gives one azimuth/elevation
// pair for the configured scan mode, in the order of the inputs. One
// transaction is taken every clock cycle while the pipeline does not stall; the
// pipeline depth is set by the two bit-serial pipelined dividers: the
// sweep phase divider (one stage per travel bit) and the raster row /
// flyback divider (32 more stages than that). A stall on the
// result side holds the whole pipeline only once a finished result waits in
// the output register and another one is ready behind it. Configuration
// writes are taken at any time and must only be made while the block is idle.
module antenna_scan_angle_generator #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int TIME_FRAC_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asg_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [asg_pkg::TIME_W-1:0]          scan_time,
  input  logic signed [asg_pkg::ANGLE_W-1:0]  pointing_azimuth,
  input  logic signed [asg_pkg::ANGLE_W-1:0]  pointing_elevation,
  input  logic                                azimuth_override,
  input  logic                                elevation_override,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [asg_pkg::ANGLE_W-1:0]  beam_azimuth,
  output logic signed [asg_pkg::ANGLE_W-1:0]  beam_elevation
);

  // travel width: 32-bit rate times 48-bit time, minus the time fraction
  localparam int DW  = 80 - TIME_FRAC_BITS;
  localparam int MW1 = DW + 1;
  localparam int NW3 = 32 + DW;
  localparam logic [33:0] CIRC_MOD = 34'(64'd360 << ANGLE_FRAC_BITS);
  localparam logic [31:0] RATE_RST = 32'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic [31:0] BARW_RST = 32'(64'd5 << ANGLE_FRAC_BITS);
  localparam logic signed [43:0] SAT_HI = 44'sh0_7FFF_FFFF;
  localparam logic signed [43:0] SAT_LO = -44'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [2:0]         cfg_mode;
  logic signed [31:0] cfg_rate;
  logic signed [31:0] cfg_start;
  logic signed [31:0] cfg_end;
  logic [47:0]        cfg_fly;
  logic [7:0]         cfg_bars;
  logic signed [31:0] cfg_barw;
  logic signed [31:0] cfg_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode  <= asg_pkg::MODE_FIXED;
      cfg_rate  <= RATE_RST;
      cfg_start <= '0;
      cfg_end   <= '0;
      cfg_fly   <= '0;
      cfg_bars  <= '0;
      cfg_barw  <= BARW_RST;
      cfg_base  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asg_pkg::REG_MODE:  cfg_mode  <= cfg_data[2:0];
        asg_pkg::REG_RATE:  cfg_rate  <= cfg_data[31:0];
        asg_pkg::REG_START: cfg_start <= cfg_data[31:0];
        asg_pkg::REG_END:   cfg_end   <= cfg_data[31:0];
        asg_pkg::REG_FLY:   cfg_fly   <= cfg_data[47:0];
        asg_pkg::REG_BARS:  cfg_bars  <= cfg_data[7:0];
        asg_pkg::REG_BARW:  cfg_barw  <= cfg_data[31:0];
        asg_pkg::REG_BASE:  cfg_base  <= cfg_data[31:0];
      endcase
    end
  end

  // values derived from configuration; the user keeps them static while items are in flight, unchecked
  logic               rate_neg;
  logic               rate_zero;
  logic [31:0]        mag;
  logic signed [32:0] sect_diff;
  logic               dir_pos;
  logic [31:0]        sect_w;
  logic               still;

  assign rate_neg  = cfg_rate[31];
  assign rate_zero = (cfg_rate == 32'sd0);
  assign mag       = rate_neg ? 32'(-cfg_rate) : cfg_rate;
  assign sect_diff = 33'(cfg_end) - 33'(cfg_start);
  assign dir_pos   = !sect_diff[32];
  assign sect_w    = sect_diff[32] ? 32'(-sect_diff) : sect_diff[31:0];
  // outside circular and fixed modes, a zero-width sector or zero rate parks the beam at the start angle
  assign still     = (sect_w == 32'd0) || rate_zero;

  // ---------------------------------------------------------------------
  // pipeline control: one enable for all stages
  // ---------------------------------------------------------------------
  logic en;
  logic v_i;

  assign en       = !v_i || !out_valid || out_ready;
  assign in_ready = en;

  // stage a: partial products of rate * time and rate * flyback
  logic               v_a;
  logic [63:0]        pt_hi_a;
  logic [47:0]        pt_lo_a;
  logic [63:0]        pf_hi_a;
  logic [47:0]        pf_lo_a;
  logic signed [31:0] pa_a;
  logic signed [31:0] pe_a;
  logic               oa_a;
  logic               oe_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_hi_a <= mag * scan_time[47:16];
      pt_lo_a <= mag * scan_time[15:0];
      pf_hi_a <= mag * cfg_fly[47:16];
      pf_lo_a <= mag * cfg_fly[15:0];
      pa_a    <= pointing_azimuth;
      pe_a    <= pointing_elevation;
      oa_a    <= azimuth_override;
      oe_a    <= elevation_override;
    end
  end

  // stage b: sum partials, drop the time fraction
  logic [79:0]        sum_t;
  logic [79:0]        sum_f;
  logic               v_b;
  logic [DW-1:0]      dd_b;
  logic [DW-1:0]      fd_b;
  logic signed [31:0] pa_b;
  logic signed [31:0] pe_b;
  logic               oa_b;
  logic               oe_b;

  assign sum_t = {pt_hi_a, 16'd0} + 80'(pt_lo_a);
  assign sum_f = {pf_hi_a, 16'd0} + 80'(pf_lo_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_b <= sum_t[79:TIME_FRAC_BITS];
      fd_b <= sum_f[79:TIME_FRAC_BITS];
      pa_b <= pa_a;
      pe_b <= pe_a;
      oa_b <= oa_a;
      oe_b <= oe_a;
    end
  end

  // stage c: pick the sweep period for the mode
  logic [MW1-1:0]     dv_next;
  logic               v_c;
  logic [MW1-1:0]     dv_c;
  logic [DW-1:0]      dd_c;
  logic [DW-1:0]      fd_c;
  logic signed [31:0] pa_c;
  logic signed [31:0] pe_c;
  logic               oa_c;
  logic               oe_c;

  always_comb begin
    unique case (cfg_mode) inside
      asg_pkg::MODE_BSECT: dv_next = MW1'({sect_w, 1'b0});
      asg_pkg::MODE_USECT,
      asg_pkg::MODE_URAST: dv_next = MW1'(sect_w) + MW1'(fd_b);
      asg_pkg::MODE_BRAST: dv_next = MW1'(sect_w);
      default:             dv_next = MW1'(CIRC_MOD);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en) begin
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c <= dv_next;
      dd_c <= dd_b;
      fd_c <= fd_b;
      pa_c <= pa_b;
      pe_c <= pe_b;
      oa_c <= oa_b;
      oe_c <= oe_b;
    end
  end

  // ---------------------------------------------------------------------
  // phase divider: travel / period
  // ---------------------------------------------------------------------
  localparam int SW1 = 66 + DW;
  logic               v_d1;
  logic [DW-1:0]      q_d1;
  logic [MW1-1:0]     r_d1;
  logic [SW1-1:0]     x_d1;
  logic [DW-1:0]      fd_d1;
  logic signed [31:0] pa_d1;
  logic signed [31:0] pe_d1;
  logic               oa_d1;
  logic               oe_d1;

  asg_div_pipe #(
    .NW(DW),
    .MW(MW1),
    .SW(SW1)
  ) u_phase_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_c),
    .num      (dd_c),
    .den      (dv_c),
    .side_in  ({fd_c, pa_c, pe_c, oa_c, oe_c}),
    .out_valid(v_d1),
    .quo      (q_d1),
    .rem      (r_d1),
    .side_out (x_d1)
  );

  assign {fd_d1, pa_d1, pe_d1, oa_d1, oe_d1} = x_d1;

  // stage e: position past the sweep end, circular wrap for negative rate
  logic               v_e;
  logic [DW-1:0]      q_e;
  logic [31:0]        loc_e;
  logic               gt_e;
  logic [DW-1:0]      delta_e;
  logic [33:0]        circ_e;
  logic [DW-1:0]      fd_e;
  logic signed [31:0] pa_e;
  logic signed [31:0] pe_e;
  logic               oa_e;
  logic               oe_e;
  logic [MW1-1:0]     delta_full;

  assign delta_full = r_d1 - MW1'(sect_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else if (en) begin
      v_e <= v_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_e     <= q_d1;
      loc_e   <= r_d1[31:0];
      gt_e    <= (r_d1 > MW1'(sect_w));
      delta_e <= delta_full[DW-1:0];
      circ_e  <= (rate_neg && (r_d1 != '0)) ? (CIRC_MOD - r_d1[33:0]) : r_d1[33:0];
      fd_e    <= fd_d1;
      pa_e    <= pa_d1;
      pe_e    <= pe_d1;
      oa_e    <= oa_d1;
      oe_e    <= oe_d1;
    end
  end

  // stage f: width times flyback progress, two partial products
  logic               v_f;
  logic [63:0]        pm_lo_f;
  logic [DW-1:0]      pm_hi_f;
  logic [DW-1:0]      q_f;
  logic [31:0]        loc_f;
  logic               gt_f;
  logic [31:0]        dl_f;
  logic [33:0]        circ_f;
  logic [DW-1:0]      fd_f;
  logic signed [31:0] pa_f;
  logic signed [31:0] pe_f;
  logic               oa_f;
  logic               oe_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else if (en) begin
      v_f <= v_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_lo_f <= sect_w * delta_e[31:0];
      pm_hi_f <= sect_w * delta_e[DW-1:32];
      q_f     <= q_e;
      loc_f   <= loc_e;
      gt_f    <= gt_e;
      dl_f    <= delta_e[31:0];
      circ_f  <= circ_e;
      fd_f    <= fd_e;
      pa_f    <= pa_e;
      pe_f    <= pe_e;
      oa_f    <= oa_e;
      oe_f    <= oe_e;
    end
  end

  // stage g: full flyback product
  logic               v_g;
  logic [NW3-1:0]     prod_g;
  logic [DW-1:0]      q_g;
  logic [31:0]        loc_g;
  logic               gt_g;
  logic [31:0]        dl_g;
  logic [33:0]        circ_g;
  logic [DW-1:0]      fd_g;
  logic signed [31:0] pa_g;
  logic signed [31:0] pe_g;
  logic               oa_g;
  logic               oe_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_g <= 1'b0;
    end else if (en) begin
      v_g <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_g <= {pm_hi_f, 32'd0} + NW3'(pm_lo_f);
      q_g    <= q_f;
      loc_g  <= loc_f;
      gt_g   <= gt_f;
      dl_g   <= dl_f;
      circ_g <= circ_f;
      fd_g   <= fd_f;
      pa_g   <= pa_f;
      pe_g   <= pe_f;
      oa_g   <= oa_f;
      oe_g   <= oe_f;
    end
  end

  // ---------------------------------------------------------------------
  // row divider (period count mod rows) and flyback divider, in lockstep
  // ---------------------------------------------------------------------
  localparam int SW3 = 163;
  logic               v_d3;
  logic [8:0]         row_d2;
  logic [1:0]         x_d2;
  logic [NW3-1:0]     q_d3;
  logic [SW3-1:0]     x_d3;
  logic [31:0]        loc_d3;
  logic               gt_d3;
  logic [31:0]        dl_d3;
  logic [33:0]        circ_d3;
  logic signed [31:0] pa_d3;
  logic signed [31:0] pe_d3;

  asg_div_pipe #(
    .NW(NW3),
    .MW(9),
    .SW(2)
  ) u_row_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_g),
    .num      (NW3'(q_g)),
    .den      (9'(cfg_bars) + 9'd1),
    .side_in  ({oa_g, oe_g}),
    .out_valid(),
    .quo      (),
    .rem      (row_d2),
    .side_out (x_d2)
  );

  asg_div_pipe #(
    .NW(NW3),
    .MW(DW),
    .SW(SW3)
  ) u_fly_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_g),
    .num      (prod_g),
    .den      (fd_g),
    .side_in  ({loc_g, gt_g, dl_g, circ_g, pa_g, pe_g}),
    .out_valid(v_d3),
    .quo      (q_d3),
    .rem      (),
    .side_out (x_d3)
  );

  assign {loc_d3, gt_d3, dl_d3, circ_d3, pa_d3, pe_d3} = x_d3;

  // stage h: reference point, signed offset, row elevation step
  logic signed [31:0] ref_pt;
  logic [33:0]        off;
  logic               neg;
  logic               az_fixed;
  logic               el_fixed;
  logic               row_step;
  logic [8:0]         row_eff;
  logic signed [35:0] ref36;
  logic signed [35:0] off36;

  logic               v_h;
  logic signed [35:0] az_h;
  logic signed [41:0] elp_h;
  logic               azf_h;
  logic               elf_h;
  logic signed [31:0] pa_h;
  logic signed [31:0] pe_h;
  logic               oa_h;
  logic               oe_h;

  always_comb begin
    ref_pt   = cfg_start;
    off      = '0;
    neg      = 1'b0;
    az_fixed = 1'b0;
    el_fixed = 1'b0;
    row_step = 1'b0;
    unique case (cfg_mode) inside
      asg_pkg::MODE_CIRC: begin
        ref_pt = '0;
        off    = rate_zero ? 34'd0 : circ_d3;
      end
      asg_pkg::MODE_BSECT: begin
        // forward sweep up to the end, then back toward the start
        if (gt_d3) begin
          ref_pt = cfg_end;
          off    = 34'(dl_d3);
          neg    = dir_pos;
        end else begin
          off = 34'(loc_d3);
          neg = !dir_pos;
        end
      end
      asg_pkg::MODE_USECT,
      asg_pkg::MODE_URAST: begin
        // linear flyback from the end after the sweep
        if (gt_d3) begin
          ref_pt = cfg_end;
          off    = 34'(q_d3[31:0]);
          neg    = dir_pos;
        end else begin
          off = 34'(loc_d3);
          neg = !dir_pos;
        end
        row_step = (cfg_mode == asg_pkg::MODE_URAST);
      end
      asg_pkg::MODE_BRAST: begin
        // odd rows run from the end back toward the start
        if (row_d2[0]) begin
          ref_pt = cfg_end;
          neg    = dir_pos;
        end else begin
          neg = !dir_pos;
        end
        off      = 34'(loc_d3);
        row_step = 1'b1;
      end
      default: begin
        az_fixed = 1'b1;
        el_fixed = 1'b1;
      end
    endcase
    if (still && (cfg_mode != asg_pkg::MODE_CIRC) && !az_fixed) begin
      ref_pt   = cfg_start;
      off      = '0;
      row_step = 1'b0;
    end
  end

  assign row_eff = row_step ? row_d2 : 9'd0;
  assign ref36   = 36'(ref_pt);
  assign off36   = $signed({2'b00, off});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_h <= 1'b0;
    end else if (en) begin
      v_h <= v_d3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_h  <= neg ? (ref36 - off36) : (ref36 + off36);
      elp_h <= $signed({1'b0, row_eff}) * cfg_barw;
      azf_h <= az_fixed;
      elf_h <= el_fixed;
      pa_h  <= pa_d3;
      pe_h  <= pe_d3;
      oa_h  <= x_d2[1];
      oe_h  <= x_d2[0];
    end
  end

  // stage i: elevation sum, saturation, override ports
  logic signed [42:0] el_sum;
  logic signed [31:0] az_i;
  logic signed [31:0] el_i;

  assign el_sum = 43'(cfg_base) + 43'(elp_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_i <= 1'b0;
    end else if (en) begin
      v_i <= v_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_i <= (oa_h || azf_h) ? pa_h : sat32(44'(az_h));
      el_i <= (oe_h || elf_h) ? pe_h : sat32(44'(el_sum));
    end
  end

  // output register, lets the pipeline run while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v_i && en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && en) begin
      beam_azimuth   <= az_i;
      beam_elevation <= el_i;
    end
  end

endmodule

@@ hw/rtl/asg_checker.sv @@
`timescale 1ns / 1ps
module asg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_ready,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [asg_pkg::ANGLE_W-1:0] beam_azimuth,
  input logic signed [asg_pkg::ANGLE_W-1:0] beam_elevation
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(beam_azimuth) && $stable(beam_elevation))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with output empty");

  // a draining output never blocks the input
  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind antenna_scan_angle_generator asg_checker u_asg_checker (.*);
